[src/rme_pkg.sv]
package rme_pkg;

  localparam int unsigned PROG_LEN = 34;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned BW_W     = 15;

  localparam logic [BW_W-1:0]    BW_RESET = 15'd128;
  localparam logic signed [31:0] TH_RESET = 32'sd167772;
  localparam logic signed [63:0] P_RESET  = 64'sd1099511627776000000;
  localparam logic signed [63:0] S64_MAX  = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN  = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;

  // scaling by reciprocal multiplication, exact over the 16-bit input range
  // phi0 = ca * 2^21 / 3193     -> ca * ceil(2^49 / 3193) >> 28
  // y    = va * 327680 / 739    -> va * 5 * ceil(2^48 / 739) >> 32
  // phi1 = rpm * 15707963 * 2^13 / 1171875 -> t * ceil(2^73 / 1171875) >> 60
  localparam logic signed [63:0] PHI0_RECIP = 64'sd176307533173;
  localparam logic signed [63:0] Y_RECIP    = 64'sd1904431506840;
  localparam logic signed [63:0] RPM_SCALE  = 64'sd15707963;
  localparam logic signed [63:0] PHI1_RECIP = 64'sd8059505464097528;

  typedef enum logic [1:0] {OP_MAC, OP_DIV, OP_ADD, OP_SUB} op_kind_e;

  typedef enum logic [5:0] {
    SRC_ZERO, SRC_ONE, SRC_BW, SRC_BWM1, SRC_IN0, SRC_IN1, SRC_IN2,
    SRC_CA, SRC_VA, SRC_TH0, SRC_TH1, SRC_P0, SRC_P1, SRC_P2, SRC_P3,
    SRC_PHI0, SRC_PHI1, SRC_Y, SRC_G0, SRC_G1, SRC_TP0, SRC_TP1,
    SRC_K0, SRC_K1, SRC_ERR, SRC_T, SRC_C16, SRC_CPHI0, SRC_CY,
    SRC_CRPM, SRC_CPHI1, SRC_C2P28
  } src_e;

  typedef struct packed {
    op_kind_e          kind;
    src_e              a0;
    src_e              b0;
    src_e              a1;
    src_e              b1;
    src_e              dst;
    logic [SHIFT_W-1:0] shift;
    logic              sat32;
  } uop_t;

  typedef struct packed {
    logic load_in;
    logic start;
    logic emit;
    uop_t uop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} ctrl_state_e;
  typedef enum logic [1:0] {PH_IDLE, PH_MAC, PH_DIV, PH_FIN} dp_phase_e;

  function automatic uop_t mk(op_kind_e k, src_e a0, src_e b0, src_e a1, src_e b1,
                              src_e dst, logic [SHIFT_W-1:0] sh, logic s32);
    uop_t u;
    u.kind  = k;
    u.a0    = a0;
    u.b0    = b0;
    u.a1    = a1;
    u.b1    = b1;
    u.dst   = dst;
    u.shift = sh;
    u.sat32 = s32;
    return u;
  endfunction

  // one update: filters, scaling, gain, covariance, estimate
  function automatic uop_t prog(logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      6'd0:  u = mk(OP_MAC, SRC_CA, SRC_BWM1, SRC_IN0, SRC_ONE, SRC_T, 6'd0, 1'b0);
      6'd1:  u = mk(OP_DIV, SRC_T, SRC_BW, SRC_ZERO, SRC_ZERO, SRC_CA, 6'd0, 1'b0);
      6'd2:  u = mk(OP_MAC, SRC_VA, SRC_BWM1, SRC_IN1, SRC_ONE, SRC_T, 6'd0, 1'b0);
      6'd3:  u = mk(OP_DIV, SRC_T, SRC_BW, SRC_ZERO, SRC_ZERO, SRC_VA, 6'd0, 1'b0);
      6'd4:  u = mk(OP_MAC, SRC_CA, SRC_CPHI0, SRC_ZERO, SRC_ZERO, SRC_PHI0, 6'd28, 1'b0);
      6'd5:  u = mk(OP_MAC, SRC_VA, SRC_CY, SRC_ZERO, SRC_ZERO, SRC_Y, 6'd32, 1'b0);
      6'd6:  u = mk(OP_MAC, SRC_IN2, SRC_CRPM, SRC_ZERO, SRC_ZERO, SRC_T, 6'd0, 1'b0);
      6'd7:  u = mk(OP_MAC, SRC_T, SRC_CPHI1, SRC_ZERO, SRC_ZERO, SRC_T, 6'd60, 1'b0);
      6'd8:  u = mk(OP_ADD, SRC_T, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_PHI1, 6'd0, 1'b1);
      6'd9:  u = mk(OP_MAC, SRC_P0, SRC_PHI0, SRC_P1, SRC_PHI1, SRC_G0, 6'd32, 1'b0);
      6'd10: u = mk(OP_MAC, SRC_P2, SRC_PHI0, SRC_P3, SRC_PHI1, SRC_G1, 6'd32, 1'b0);
      6'd11: u = mk(OP_MAC, SRC_PHI0, SRC_P0, SRC_PHI1, SRC_P2, SRC_TP0, 6'd32, 1'b0);
      6'd12: u = mk(OP_MAC, SRC_PHI0, SRC_P1, SRC_PHI1, SRC_P3, SRC_TP1, 6'd32, 1'b0);
      6'd13: u = mk(OP_MAC, SRC_TP0, SRC_PHI0, SRC_TP1, SRC_PHI1, SRC_T, 6'd20, 1'b0);
      6'd14: u = mk(OP_ADD, SRC_T, SRC_C2P28, SRC_ZERO, SRC_ZERO, SRC_T, 6'd0, 1'b0);
      6'd15: u = mk(OP_DIV, SRC_G0, SRC_T, SRC_ZERO, SRC_ZERO, SRC_K0, 6'd40, 1'b0);
      6'd16: u = mk(OP_DIV, SRC_G1, SRC_T, SRC_ZERO, SRC_ZERO, SRC_K1, 6'd40, 1'b0);
      6'd17: u = mk(OP_MAC, SRC_K0, SRC_TP0, SRC_ZERO, SRC_ZERO, SRC_T, 6'd28, 1'b0);
      6'd18: u = mk(OP_SUB, SRC_P0, SRC_T, SRC_ZERO, SRC_ZERO, SRC_P0, 6'd0, 1'b0);
      6'd19: u = mk(OP_MAC, SRC_K0, SRC_TP1, SRC_ZERO, SRC_ZERO, SRC_T, 6'd28, 1'b0);
      6'd20: u = mk(OP_SUB, SRC_P1, SRC_T, SRC_ZERO, SRC_ZERO, SRC_P1, 6'd0, 1'b0);
      6'd21: u = mk(OP_MAC, SRC_K1, SRC_TP0, SRC_ZERO, SRC_ZERO, SRC_T, 6'd28, 1'b0);
      6'd22: u = mk(OP_SUB, SRC_P2, SRC_T, SRC_ZERO, SRC_ZERO, SRC_P2, 6'd0, 1'b0);
      6'd23: u = mk(OP_MAC, SRC_K1, SRC_TP1, SRC_ZERO, SRC_ZERO, SRC_T, 6'd28, 1'b0);
      6'd24: u = mk(OP_SUB, SRC_P3, SRC_T, SRC_ZERO, SRC_ZERO, SRC_P3, 6'd0, 1'b0);
      6'd25: u = mk(OP_MAC, SRC_P0, SRC_PHI0, SRC_P1, SRC_PHI1, SRC_G0, 6'd20, 1'b0);
      6'd26: u = mk(OP_MAC, SRC_P2, SRC_PHI0, SRC_P3, SRC_PHI1, SRC_G1, 6'd20, 1'b0);
      6'd27: u = mk(OP_MAC, SRC_PHI0, SRC_TH0, SRC_PHI1, SRC_TH1, SRC_T, 6'd20, 1'b0);
      6'd28: u = mk(OP_MAC, SRC_Y, SRC_C16, SRC_ZERO, SRC_ZERO, SRC_ERR, 6'd0, 1'b0);
      6'd29: u = mk(OP_SUB, SRC_ERR, SRC_T, SRC_ZERO, SRC_ZERO, SRC_ERR, 6'd0, 1'b0);
      6'd30: u = mk(OP_MAC, SRC_G0, SRC_ERR, SRC_ZERO, SRC_ZERO, SRC_T, 6'd40, 1'b0);
      6'd31: u = mk(OP_ADD, SRC_TH0, SRC_T, SRC_ZERO, SRC_ZERO, SRC_TH0, 6'd0, 1'b1);
      6'd32: u = mk(OP_MAC, SRC_G1, SRC_ERR, SRC_ZERO, SRC_ZERO, SRC_T, 6'd40, 1'b0);
      6'd33: u = mk(OP_ADD, SRC_TH1, SRC_T, SRC_ZERO, SRC_ZERO, SRC_TH1, 6'd0, 1'b1);
      default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, 6'd0, 1'b0);
    endcase
    return u;
  endfunction

endpackage

[src/rls_motor_param_estimator.sv]
// Two-parameter recursive least squares estimator of winding resistance and
// flux linkage (Q8.24), fed with raw q-axis current, voltage and speed in rpm.
// Every accepted sample yields one result transfer holding both estimates.
// For each sample a sequencer runs 34 micro-operations on a shared datapath,
// where each 64x64 product sum is formed on one 32x32 multiplier (the fixed
// scalings are reciprocal multiplications) and each of the four divisions
// (two filter divisions, two gain divisions) runs in the radix-2 divider. A
// finished result waits in an output register; the next sample is taken once
// the update is done and its result has moved into that register.
// Register 0 at address 0 is the filter bandwidth (reset 128, 0 acts as 1).
module rls_motor_param_estimator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] current_q_sample_i,
  input  logic signed [15:0] voltage_q_sample_i,
  input  logic signed [15:0] speed_rpm_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] resistance_estimate_o,
  output logic signed [31:0] flux_estimate_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rme_pkg::*;

  logic [BW_W-1:0] bw_q;
  logic            out_valid_q;
  logic signed [31:0] res0_q, res1_q, th0, th1;
  logic            out_free;
  ctrl_cmd_t       cmd;
  dp_status_t      status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-BW_W){1'b0}}, bw_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= BW_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      bw_q <= pwdata[BW_W-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  rme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  rme_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .bw_i               (bw_q),
    .current_q_sample_i (current_q_sample_i),
    .voltage_q_sample_i (voltage_q_sample_i),
    .speed_rpm_i        (speed_rpm_i),
    .status_o           (status),
    .th0_o              (th0),
    .th1_o              (th1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      res0_q <= th0;
      res1_q <= th1;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign resistance_estimate_o = res0_q;
  assign flux_estimate_o       = res1_q;

endmodule

[src/rme_ctrl.sv]
module rme_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   out_free_i,
  input  rme_pkg::dp_status_t    status_i,
  output logic                   in_ready_o,
  output rme_pkg::ctrl_cmd_t     cmd_o
);
  import rme_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROG_LEN - 1);

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_ISSUE;
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (status_i.done) state_d = (step_q == LAST_STEP) ? ST_OUT : ST_ISSUE;
      end
      ST_OUT:   if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load_in = 1'b0;
    cmd_o.start   = 1'b0;
    cmd_o.emit    = 1'b0;
    cmd_o.uop     = prog(step_q);
    step_d        = step_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        step_d        = '0;
      end
      ST_ISSUE: cmd_o.start = 1'b1;
      ST_WAIT:  if (status_i.done) step_d = step_q + 1'b1;
      ST_OUT:   cmd_o.emit = out_free_i;
      default:  step_d = '0;
    endcase
  end

endmodule

[src/rme_datapath.sv]
module rme_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rme_pkg::ctrl_cmd_t            cmd_i,
  input  logic [rme_pkg::BW_W-1:0]      bw_i,
  input  logic signed [15:0]            current_q_sample_i,
  input  logic signed [15:0]            voltage_q_sample_i,
  input  logic signed [15:0]            speed_rpm_i,
  output rme_pkg::dp_status_t           status_o,
  output logic signed [31:0]            th0_o,
  output logic signed [31:0]            th1_o
);
  import rme_pkg::*;

  logic signed [15:0] ca_q, va_q, in0_q, in1_q, in2_q;
  logic signed [31:0] th0_q, th1_q, phi0_q, phi1_q, y_q;
  logic signed [63:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [63:0] g0_q, g1_q, tp0_q, tp1_q, k0_q, k1_q, err_q, t_q;

  logic [BW_W-1:0] bw_eff, bw_m1;
  assign bw_eff = (bw_i == '0) ? BW_W'(1) : bw_i;
  assign bw_m1  = bw_eff - 1'b1;

  function automatic logic signed [63:0] pick(src_e s);
    logic signed [63:0] v;
    case (s)
      SRC_ZERO:       v = '0;
      SRC_ONE:        v = 64'sd1;
      SRC_BW:         v = {{(64-BW_W){1'b0}}, bw_eff};
      SRC_BWM1:       v = {{(64-BW_W){1'b0}}, bw_m1};
      SRC_IN0:        v = 64'(in0_q);
      SRC_IN1:        v = 64'(in1_q);
      SRC_IN2:        v = 64'(in2_q);
      SRC_CA:         v = 64'(ca_q);
      SRC_VA:         v = 64'(va_q);
      SRC_TH0:        v = 64'(th0_q);
      SRC_TH1:        v = 64'(th1_q);
      SRC_P0:         v = p0_q;
      SRC_P1:         v = p1_q;
      SRC_P2:         v = p2_q;
      SRC_P3:         v = p3_q;
      SRC_PHI0:       v = 64'(phi0_q);
      SRC_PHI1:       v = 64'(phi1_q);
      SRC_Y:          v = 64'(y_q);
      SRC_G0:         v = g0_q;
      SRC_G1:         v = g1_q;
      SRC_TP0:        v = tp0_q;
      SRC_TP1:        v = tp1_q;
      SRC_K0:         v = k0_q;
      SRC_K1:         v = k1_q;
      SRC_ERR:        v = err_q;
      SRC_T:          v = t_q;
      SRC_C16:        v = 64'sd16;
      SRC_CPHI0:      v = PHI0_RECIP;
      SRC_CY:         v = Y_RECIP;
      SRC_CRPM:       v = RPM_SCALE;
      SRC_CPHI1:      v = PHI1_RECIP;
      SRC_C2P28:      v = 64'sd268435456;
      default:        v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  dp_phase_e    phase_q, phase_d;
  uop_t         uop_q;
  logic [3:0]   mcnt_q;
  logic [63:0]  pp_q, pp_d;
  logic [1:0]   ppk_q, ppk_d;
  logic         ppneg_q, ppneg_d;
  logic signed [128:0] acc_q, acc_d;
  logic [127:0] num_q;
  logic [63:0]  dm_q;
  logic [64:0]  rem_q, rem_d;
  logic [62:0]  quo_q;
  logic         ovf_q, dneg_q, dzero_q, ge;
  logic [6:0]   idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= PH_IDLE;
    else         phase_q <= phase_d;
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: begin
        if (cmd_i.start) begin
          case (cmd_i.uop.kind)
            OP_MAC:  phase_d = PH_MAC;
            OP_DIV:  phase_d = PH_DIV;
            default: phase_d = PH_FIN;
          endcase
        end
      end
      PH_MAC:  if (mcnt_q == 4'd8) phase_d = PH_FIN;
      PH_DIV:  if (idx_q == '0) phase_d = PH_FIN;
      PH_FIN:  phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  // partial products of two 64x64 magnitude products, 32x32 each
  logic signed [63:0] ma, mb;
  logic [63:0] mam, mbm;
  logic [31:0] ap, bp;
  logic [128:0] term;
  always_comb begin
    ma      = mcnt_q[2] ? pick(uop_q.a1) : pick(uop_q.a0);
    mb      = mcnt_q[2] ? pick(uop_q.b1) : pick(uop_q.b0);
    mam     = mag64(ma);
    mbm     = mag64(mb);
    ap      = mcnt_q[0] ? mam[63:32] : mam[31:0];
    bp      = mcnt_q[1] ? mbm[63:32] : mbm[31:0];
    pp_d    = ap * bp;
    ppk_d   = {1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]};
    ppneg_d = ma[63] ^ mb[63];
    term    = {65'b0, pp_q} << {ppk_q, 5'b0};
    acc_d   = ppneg_q ? acc_q - $signed(term) : acc_q + $signed(term);
  end

  // restoring division, one quotient bit a cycle
  logic [64:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[63:0], num_q[idx_q]};
    ge     = rem_sh >= {1'b0, dm_q};
    rem_d  = ge ? rem_sh - {1'b0, dm_q} : rem_sh;
  end

  logic signed [63:0] sa, sb;
  logic [6:0] div_top;
  always_comb begin
    sa      = pick(cmd_i.uop.a0);
    sb      = pick(cmd_i.uop.b0);
    div_top = 7'd63 + {1'b0, cmd_i.uop.shift};
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && cmd_i.start) begin
      uop_q   <= cmd_i.uop;
      mcnt_q  <= '0;
      acc_q   <= '0;
      num_q   <= {64'b0, mag64(sa)} << cmd_i.uop.shift;
      dm_q    <= mag64(sb);
      rem_q   <= '0;
      quo_q   <= '0;
      ovf_q   <= 1'b0;
      dneg_q  <= sa[63] ^ sb[63];
      dzero_q <= (sb == '0);
      idx_q   <= div_top;
    end else begin
      if (phase_q == PH_MAC) begin
        mcnt_q  <= mcnt_q + 1'b1;
        pp_q    <= pp_d;
        ppk_q   <= ppk_d;
        ppneg_q <= ppneg_d;
        if (mcnt_q != '0) acc_q <= acc_d;
      end
      if (phase_q == PH_DIV) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[61:0], ge};
        if (ge && idx_q >= 7'd63) ovf_q <= 1'b1;
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  // results at the final cycle of an operation
  logic               aneg;
  logic [128:0]       amag, msh;
  logic signed [63:0] mac_res, div_res, alu_res, wr_val;
  logic signed [64:0] sum65;
  always_comb begin
    aneg = acc_q[128];
    amag = aneg ? 129'(-acc_q) : 129'(acc_q);
    msh  = amag >> uop_q.shift;
    if (|msh[128:63]) mac_res = aneg ? S64_MIN : S64_MAX;
    else              mac_res = aneg ? -$signed(msh[63:0]) : $signed(msh[63:0]);

    if (dzero_q)     div_res = '0;
    else if (ovf_q)  div_res = dneg_q ? S64_MIN : S64_MAX;
    else             div_res = dneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

    if (uop_q.kind == OP_SUB) sum65 = 65'(pick(uop_q.a0)) - 65'(pick(uop_q.b0));
    else                      sum65 = 65'(pick(uop_q.a0)) + 65'(pick(uop_q.b0));
    if (sum65[64] != sum65[63]) alu_res = sum65[64] ? S64_MIN : S64_MAX;
    else                        alu_res = sum65[63:0];
    if (uop_q.sat32) begin
      if (alu_res > S32_MAX)      alu_res = S32_MAX;
      else if (alu_res < S32_MIN) alu_res = S32_MIN;
    end

    case (uop_q.kind)
      OP_MAC:  wr_val = mac_res;
      OP_DIV:  wr_val = div_res;
      default: wr_val = alu_res;
    endcase
  end

  logic wr_en;
  assign wr_en = (phase_q == PH_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q  <= '0;
      va_q  <= '0;
      th0_q <= TH_RESET;
      th1_q <= TH_RESET;
      p0_q  <= P_RESET;
      p1_q  <= '0;
      p2_q  <= '0;
      p3_q  <= P_RESET;
    end else if (wr_en) begin
      case (uop_q.dst)
        SRC_CA:  ca_q  <= wr_val[15:0];
        SRC_VA:  va_q  <= wr_val[15:0];
        SRC_TH0: th0_q <= wr_val[31:0];
        SRC_TH1: th1_q <= wr_val[31:0];
        SRC_P0:  p0_q  <= wr_val;
        SRC_P1:  p1_q  <= wr_val;
        SRC_P2:  p2_q  <= wr_val;
        SRC_P3:  p3_q  <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in0_q <= current_q_sample_i;
      in1_q <= voltage_q_sample_i;
      in2_q <= speed_rpm_i;
    end
    if (wr_en) begin
      case (uop_q.dst)
        SRC_PHI0: phi0_q <= wr_val[31:0];
        SRC_PHI1: phi1_q <= wr_val[31:0];
        SRC_Y:    y_q    <= wr_val[31:0];
        SRC_G0:   g0_q   <= wr_val;
        SRC_G1:   g1_q   <= wr_val;
        SRC_TP0:  tp0_q  <= wr_val;
        SRC_TP1:  tp1_q  <= wr_val;
        SRC_K0:   k0_q   <= wr_val;
        SRC_K1:   k1_q   <= wr_val;
        SRC_ERR:  err_q  <= wr_val;
        SRC_T:    t_q    <= wr_val;
        default: ;
      endcase
    end
  end

  assign status_o.done = wr_en;
  assign th0_o = th0_q;
  assign th1_o = th1_q;

endmodule

[src/rme_checker.sv]
module rme_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] resistance_estimate_o,
  input logic signed [31:0] flux_estimate_o
);

  // one sample in flight: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an update runs");

  // a result only appears at the end of an update
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without an update");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(resistance_estimate_o)
      && $stable(flux_estimate_o))
    else $error("stalled result changed");

endmodule

bind rls_motor_param_estimator rme_checker u_rme_checker (.*);
